[rtl/adc_ma_pkg.sv]
`default_nettype none

package adc_ma_pkg;

  // Field widths.
  localparam int unsigned SampleW = 12;
  localparam int unsigned MeanW   = 12;
  localparam int unsigned MvW     = 13;

  // Converter full scale in counts and the matching reference in millivolts.
  localparam int unsigned CountsFull = 4095;
  localparam logic [MvW-1:0] MvFull  = 13'd5000;

  // floor(mean * 5000 / 4095) == (mean * MvMul) >> MvShift for every 12-bit mean.
  // MvMul is the reciprocal rounded up; the shift is large enough that the
  // rounding error never reaches the next integer.
  localparam int unsigned MvShift   = 24;
  localparam int unsigned MvMulW    = 25;
  localparam logic [MvMulW-1:0] MvMul =
    MvMulW'(((64'd5000 << MvShift) + 64'd4094) / 64'd4095);
  localparam int unsigned MvProdW   = MeanW + MvMulW;

  // Load enables for the two result stages of the scaling unit.
  typedef struct packed {
    logic mean_en;
    logic out_en;
  } scale_ctl_t;

endpackage

`default_nettype wire

[rtl/adc_ma_ring.sv]
`default_nettype none

module adc_ma_ring #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             wr_en_i,
  input  wire logic [adc_ma_pkg::SampleW-1:0]   sample_i,
  output logic      [adc_ma_pkg::SampleW-1:0]   sample_o,
  output logic      [adc_ma_pkg::SampleW-1:0]   old_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);

  logic [adc_ma_pkg::SampleW-1:0] ring_q [DEPTH];
  logic [DEPTH-1:0]               fill_q;
  logic [PtrW-1:0]                ptr_q;
  logic [PtrW-1:0]                ptr_d;
  logic [adc_ma_pkg::SampleW-1:0] old_q;
  logic                           old_vld_q;
  logic [adc_ma_pkg::SampleW-1:0] sample_q;

  assign ptr_d = (ptr_q == LastSlot) ? '0 : ptr_q + PtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      fill_q    <= '0;
      old_vld_q <= 1'b0;
    end else if (wr_en_i) begin
      ptr_q          <= ptr_d;
      fill_q[ptr_q]  <= 1'b1;
      old_vld_q      <= fill_q[ptr_q];
    end
  end

  // The entry is read before it is overwritten in the same edge.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_q[ptr_q] <= sample_i;
      old_q         <= ring_q[ptr_q];
      sample_q      <= sample_i;
    end
  end

  // An entry never written since reset reads as zero.
  assign old_o    = old_vld_q ? old_q : '0;
  assign sample_o = sample_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LastSlot)
    else $error("ring write pointer beyond last slot");

  a_ptr_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && ptr_q == LastSlot |=> ptr_q == '0)
    else $error("ring write pointer did not wrap");

endmodule

`default_nettype wire

[rtl/adc_ma_accum.sv]
`default_nettype none

module adc_ma_accum #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire logic [adc_ma_pkg::SampleW-1:0]         sample_i,
  input  wire logic [adc_ma_pkg::SampleW-1:0]         old_i,
  output logic [$clog2(DEPTH*adc_ma_pkg::CountsFull+1)-1:0] total_o
);

  localparam int unsigned TotW = $clog2(DEPTH * adc_ma_pkg::CountsFull + 1);
  localparam logic [TotW-1:0] TotMax = TotW'(DEPTH * adc_ma_pkg::CountsFull);

  logic [TotW-1:0] total_q;
  logic [TotW-1:0] total_d;

  // The true sum never goes negative, so wrapping arithmetic is exact.
  assign total_d = total_q - TotW'(old_i) + TotW'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (en_i) begin
      total_q <= total_d;
    end
  end

  assign total_o = total_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotMax)
    else $error("running total exceeds full ring sum");

endmodule

`default_nettype wire

[rtl/adc_ma_scale.sv]
`default_nettype none

module adc_ma_scale #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire adc_ma_pkg::scale_ctl_t                        ctl_i,
  input  wire logic [$clog2(DEPTH*adc_ma_pkg::CountsFull+1)-1:0] total_i,
  output logic      [adc_ma_pkg::MeanW-1:0]                  mean_raw_o,
  output logic      [adc_ma_pkg::MvW-1:0]                    millivolts_o
);

  localparam int unsigned TotW     = $clog2(DEPTH * adc_ma_pkg::CountsFull + 1);
  localparam int unsigned DivShift = TotW + $clog2(DEPTH);
  localparam int unsigned ProdW    = 2 * TotW + 1;
  // Reciprocal of DEPTH rounded up; with this shift the quotient is exact for
  // every total that fits TotW bits.
  localparam logic [TotW:0] DivMul =
    (TotW+1)'(((64'd1 << DivShift) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  logic [ProdW-1:0]                  div_prod;
  logic [adc_ma_pkg::MvProdW-1:0]    mv_prod;
  logic [adc_ma_pkg::MeanW-1:0]      mean_q;
  logic [adc_ma_pkg::MeanW-1:0]      mean_out_q;
  logic [adc_ma_pkg::MvW-1:0]        mv_q;

  assign div_prod = ProdW'(total_i) * ProdW'(DivMul);
  assign mv_prod  = adc_ma_pkg::MvProdW'(mean_q) *
                    adc_ma_pkg::MvProdW'(adc_ma_pkg::MvMul);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mean_en) begin
      mean_q <= div_prod[DivShift +: adc_ma_pkg::MeanW];
    end
    if (ctl_i.out_en) begin
      mean_out_q <= mean_q;
      mv_q       <= mv_prod[adc_ma_pkg::MvShift +: adc_ma_pkg::MvW];
    end
  end

  assign mean_raw_o   = mean_out_q;
  assign millivolts_o = mv_q;

endmodule

`default_nettype wire

[rtl/adc_moving_average_millivolts.sv]
`default_nettype none

// Boxcar moving average over the last DEPTH converter samples, with the mean
// also given in millivolts for a 5 V reference (floor(mean * 5000 / 4095)).
// One sample is taken per clock unless the input is stalled, and every sample
// yields exactly one result. Each sample passes through the ring read register,
// the running total, the mean register and the output register in that order.
// The sustained rate of one sample per cycle, while the output is not stalled,
// is set by the ring buffer, which does one read and one write of the same slot
// per sample, and by the running-total adder that subtracts the outgoing sample
// and adds the new one. The ring counts as all zeros after reset, so the first
// DEPTH-1 means include zeros; the per-entry fill flags are cleared by reset at
// once and no clearing pass is needed. Division by DEPTH and the millivolt
// scaling are exact reciprocal multiplications, each followed by a register.
module adc_moving_average_millivolts #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [adc_ma_pkg::SampleW-1:0]     sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [adc_ma_pkg::MeanW-1:0]       mean_raw_o,
  output logic      [adc_ma_pkg::MvW-1:0]         millivolts_o
);

  localparam int unsigned TotW = $clog2(DEPTH * adc_ma_pkg::CountsFull + 1);

  // Stage valid flags: ring read, running total, mean, result.
  logic vld1_q, vld2_q, vld3_q, vld4_q;
  logic vld1_d, vld2_d, vld3_d, vld4_d;
  // A stage loads when it is empty or when the stage after it loads, so
  // bubbles collapse and input is refused only with every stage full.
  logic ld1, ld2, ld3, ld4;
  logic in_xfer;

  logic [adc_ma_pkg::SampleW-1:0] s1_sample;
  logic [adc_ma_pkg::SampleW-1:0] s1_old;
  logic [TotW-1:0]                total;
  adc_ma_pkg::scale_ctl_t         scale_ctl;

  assign ld4 = !vld4_q || !out_stall_i;
  assign ld3 = !vld3_q || ld4;
  assign ld2 = !vld2_q || ld3;
  assign ld1 = !vld1_q || ld2;

  assign in_stall_o = !ld1;
  assign in_xfer    = in_valid_i && ld1;

  always_comb begin
    vld1_d = ld1 ? in_valid_i : vld1_q;
    vld2_d = ld2 ? vld1_q     : vld2_q;
    vld3_d = ld3 ? vld2_q     : vld3_q;
    vld4_d = ld4 ? vld3_q     : vld4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= vld1_d;
      vld2_q <= vld2_d;
      vld3_q <= vld3_d;
      vld4_q <= vld4_d;
    end
  end

  // Stage 1: write the new sample into the ring and fetch the one it replaces.
  adc_ma_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (in_xfer),
    .sample_i(sample_i),
    .sample_o(s1_sample),
    .old_o   (s1_old)
  );

  // Stage 2: the running total only moves when a real sample enters it.
  adc_ma_accum #(
    .DEPTH(DEPTH)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ld2 && vld1_q),
    .sample_i(s1_sample),
    .old_i   (s1_old),
    .total_o (total)
  );

  // Stages 3 and 4: mean, then millivolts alongside the output register.
  assign scale_ctl.mean_en = ld3 && vld2_q;
  assign scale_ctl.out_en  = ld4 && vld3_q;

  adc_ma_scale #(
    .DEPTH(DEPTH)
  ) u_scale (
    .clk_i       (clk_i),
    .ctl_i       (scale_ctl),
    .total_i     (total),
    .mean_raw_o  (mean_raw_o),
    .millivolts_o(millivolts_o)
  );

  assign out_valid_o = vld4_q;

  a_mv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> millivolts_o <= adc_ma_pkg::MvFull)
    else $error("millivolt result above full scale");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q && vld2_q && vld3_q && vld4_q && out_stall_i |-> in_stall_o)
    else $error("input taken while the pipeline is full and stalled");

  a_empty_out_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld4_q |-> !in_stall_o)
    else $error("input stalled while the result stage is empty");

endmodule

`default_nettype wire

[bench/adc_ma_checker.sv]
`default_nettype none

// Watches both channels of the moving-average block, keeps its own copy of the
// sample window and queues the expected mean and millivolt value for every
// input transfer. Each output transfer is compared with the oldest entry.
module adc_ma_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_stall_i,
  input  wire logic [adc_ma_pkg::SampleW-1:0] sample_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_stall_i,
  input  wire logic [adc_ma_pkg::MeanW-1:0]   mean_raw_i,
  input  wire logic [adc_ma_pkg::MvW-1:0]     millivolts_i,
  output int                                  mismatches_o,
  output int                                  outstanding_o
);

  typedef struct packed {
    logic [adc_ma_pkg::MeanW-1:0] mean_raw;
    logic [adc_ma_pkg::MvW-1:0]   millivolts;
  } avg_result_t;

  logic [adc_ma_pkg::SampleW-1:0] window [DEPTH];
  int unsigned                    slot;
  int unsigned                    window_sum;
  int                             errs;
  avg_result_t                    awaited_q [$];

  // Replaces the oldest sample in the window and queues the resulting averages.
  task automatic push_average(input logic [adc_ma_pkg::SampleW-1:0] s);
    int unsigned mean;
    int unsigned mv;
    avg_result_t r;
    window_sum = window_sum - window[slot] + s;
    window[slot] = s;
    slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
    mean = window_sum / DEPTH;
    mv = (mean * adc_ma_pkg::MvFull) / adc_ma_pkg::CountsFull;
    r.mean_raw = adc_ma_pkg::MeanW'(mean);
    r.millivolts = adc_ma_pkg::MvW'(mv);
    awaited_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    avg_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) window[k] = '0;
      slot = 0;
      window_sum = 0;
      errs = 0;
      awaited_q.delete();
      mismatches_o <= 0;
      outstanding_o <= 0;
    end else begin
      // Results leave before the new sample is folded in; a result can never
      // belong to a sample taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected result: mean_raw %0d millivolts %0d", mean_raw_i, millivolts_i);
          errs++;
        end else begin
          want = awaited_q.pop_front();
          if (mean_raw_i !== want.mean_raw) begin
            $error("mean_raw: expected %0d, got %0d", want.mean_raw, mean_raw_i);
            errs++;
          end
          if (millivolts_i !== want.millivolts) begin
            $error("millivolts: expected %0d, got %0d", want.millivolts, millivolts_i);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) push_average(sample_i);
      mismatches_o <= errs;
      outstanding_o <= awaited_q.size();
    end
  end

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

// Top of the moving-average bench. This module only produces stimulus, shapes
// the stall pattern of the result side and gives the verdict; all prediction
// and comparison lives in the checker instantiated next to the block.
module tb;

  localparam int unsigned Depth      = 16;
  // Cycles without any transfer on either channel before the run is abandoned.
  // The longest legitimate gap is the deliberate receiver hold-off below.
  localparam int          IdleLimit  = 2000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int          HoldCycles = 150;
  // Margin after the last expected result, covering the block's pipeline registers.
  localparam int          DrainWait  = 16;

  // Kinds of sample patterns used in the random part, chosen per run of 32.
  typedef enum int {
    PatUniform,
    PatFullScale,
    PatRails,
    PatNearLevel
  } pattern_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic [adc_ma_pkg::SampleW-1:0] sample_i    = '0;
  logic                           out_stall_i = 1'b0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic [adc_ma_pkg::MeanW-1:0]   mean_raw_o;
  logic [adc_ma_pkg::MvW-1:0]     millivolts_o;

  int mismatches;
  int outstanding;

  // Idle percentages: the sender's is private to the stimulus process, the
  // receiver's is handed over with a nonblocking write so the stall process
  // always sees a settled value.
  int send_idle_pct = 17;
  int recv_idle_pct = 62;

  // The stimulus bumps hold_req to ask for one long hold-off; the receiver
  // process notices the change and counts the hold-off down on its own.
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  adc_moving_average_millivolts #(
    .DEPTH(Depth)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_raw_o  (mean_raw_o),
    .millivolts_o(millivolts_o)
  );

  adc_ma_checker #(
    .DEPTH(Depth)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mean_raw_i   (mean_raw_o),
    .millivolts_i (millivolts_o),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // Offers one sample and returns at the edge where it is transferred. Idle
  // cycles are inserted before the offer; once valid is up, the sample holds
  // steady until the block takes it.
  task automatic send(input logic [adc_ma_pkg::SampleW-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Random samples in runs of 32 that share a pattern. Full-scale runs and
  // runs around one level let the window settle, so the mean really reaches
  // the top and the bottom rather than hovering around mid scale.
  task automatic run_phase(input int n);
    pattern_e                       pat;
    int                             level;
    logic [adc_ma_pkg::SampleW-1:0] s;
    pat = PatUniform;
    level = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        pat = pattern_e'($urandom_range(3));
        level = $urandom_range(4095);
      end
      case (pat)
        PatUniform: begin
          s = adc_ma_pkg::SampleW'($urandom);
        end
        PatFullScale: begin
          s = '1;
        end
        PatRails: begin
          s = $urandom_range(1) ? adc_ma_pkg::SampleW'($urandom_range(15))
                                : adc_ma_pkg::SampleW'(4080 + $urandom_range(15));
        end
        default: begin
          s = adc_ma_pkg::SampleW'(level + $urandom_range(31));
        end
      endcase
      send(s);
    end
  endtask

  // Result side. Outside the hold-off, the receiver stalls at random with the
  // percentage of the current phase.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first samples land in a window that is still mostly
    // zeros after reset. Seventeen full-scale samples then fill the window and
    // wrap the write pointer, so the mean hits full scale and 5000 mV. Alternating
    // bit patterns, values next to the ends, mid scale and finally zero follow, each
    // one displacing a full-scale entry.
    send('0);
    repeat (17) send('1);
    send(12'h555);
    send(12'hAAA);
    send(12'd1);
    send(12'd2048);
    send(12'd4094);
    send('0);

    // Phase one: sender idles a little, receiver a lot.
    run_phase(700);

    // Phase two: the other way round.
    send_idle_pct = 62;
    recv_idle_pct <= 17;
    run_phase(650);

    // Phase three: no idling on either side. It opens with a long receiver
    // hold-off while the sender keeps pushing, so the block fills and stalls
    // its input.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= hold_req + 1;
    run_phase(650);

    in_valid_i <= 1'b0;

    // Wait for every expected result, then give the block time to show any
    // surplus output. The watchdog bounds the first wait.
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
